### hdl/otla_pkg.sv
package otla_pkg;

    // Window depth used when the top level is not overridden.
    localparam int WINDOW_DEFAULT = 70;

    // Temperature range of the sensor curve, in degrees C.
    localparam int TEMP_MIN = 20;
    localparam int TEMP_MAX = 100;

    // Field widths.
    localparam int RES_W     = 16;
    localparam int TEMP_W    = 7;
    localparam int CFG_W     = 16;
    localparam int IDX_W     = 2;
    localparam int SPAN_W    = 6;
    localparam int RCP_W     = 11;
    localparam int RCP_SHIFT = 12;
    localparam int PROD_W    = SPAN_W + RCP_W;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_ALARM_LIMIT = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SENSOR_LO   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SENSOR_HI   = 2'd2;

    // Configuration reset values.
    localparam logic [TEMP_W-1:0] ALARM_LIMIT_RST = 7'd90;
    localparam logic [CFG_W-1:0]  SENSOR_LO_RST   = 16'd300;
    localparam logic [CFG_W-1:0]  SENSOR_HI_RST   = 16'd60000;

    // Piecewise-linear sensor curve: each segment starts at SEG_LO with the
    // temperature SEG_T0. SEG_RCP is the segment slope (rise over span)
    // scaled by 2^RCP_SHIFT and rounded up; for every offset inside the
    // segment the top bits of offset * SEG_RCP equal the truncated quotient.
    localparam int SEG_COUNT = 14;
    localparam logic [RES_W-1:0] RES_TOP = 16'd1385;

    localparam logic [RES_W-1:0] SEG_LO [SEG_COUNT] = '{
        16'd1077, 16'd1116, 16'd1155, 16'd1174, 16'd1194, 16'd1213, 16'd1232,
        16'd1251, 16'd1270, 16'd1289, 16'd1309, 16'd1328, 16'd1347, 16'd1366
    };
    localparam logic [TEMP_W-1:0] SEG_T0 [SEG_COUNT] = '{
        7'd20, 7'd30, 7'd40, 7'd45, 7'd50, 7'd55, 7'd60,
        7'd65, 7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95
    };
    localparam logic [RCP_W-1:0] SEG_RCP [SEG_COUNT] = '{
        11'd1051, 11'd1051, 11'd1078, 11'd1024, 11'd1078, 11'd1078, 11'd1078,
        11'd1078, 11'd1078, 11'd1024, 11'd1078, 11'd1078, 11'd1078, 11'd1078
    };

    typedef struct packed {
        logic [RES_W-1:0]  lo;
        logic [TEMP_W-1:0] t0;
        logic [RCP_W-1:0]  rcp;
    } otla_seg_t;

    // Selects the segment that holds r. Outside the curve the slope is zero,
    // so the interpolation term vanishes.
    function automatic otla_seg_t seg_lookup(input logic [RES_W-1:0] r);
        otla_seg_t seg;
        seg.lo  = '0;
        seg.t0  = TEMP_W'(TEMP_MIN);
        seg.rcp = '0;
        for (int k = 0; k < SEG_COUNT; k++) begin
            if (r >= SEG_LO[k]) begin
                seg.lo  = SEG_LO[k];
                seg.t0  = SEG_T0[k];
                seg.rcp = SEG_RCP[k];
            end
        end
        if (r >= RES_TOP) begin
            seg.lo  = '0;
            seg.t0  = TEMP_W'(TEMP_MAX);
            seg.rcp = '0;
        end
        return seg;
    endfunction

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LIN   = 5'b00010,
        ST_UPD   = 5'b00100,
        ST_SWAIT = 5'b01000,
        ST_OUT   = 5'b10000
    } otla_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic lat_in;
        logic div_start;
        logic ram_rd;
        logic win_upd;
        logic filt_load;
        logic out_load;
    } otla_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
    } otla_status_t;

endpackage

### hdl/otla_ram.sv
module otla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/otla_div.sv
module otla_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    // Restoring division, one quotient bit per cycle, most significant first.
    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

### hdl/otla_dp.sv
module otla_dp #(
    parameter int WINDOW = otla_pkg::WINDOW_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  otla_pkg::otla_cmd_t          cmd,
    output otla_pkg::otla_status_t       status,
    input  logic [otla_pkg::RES_W-1:0]   res_in,
    input  logic                         cfg_we,
    input  logic [otla_pkg::IDX_W-1:0]   cfg_index,
    input  logic [otla_pkg::CFG_W-1:0]   cfg_data,
    output logic [otla_pkg::TEMP_W-1:0]  filtered_temp,
    output logic                         high_alarm,
    output logic                         sensor_error
);

    localparam int TW     = otla_pkg::TEMP_W;
    localparam int PTR_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(otla_pkg::TEMP_MAX * WINDOW + 1);

    // Configuration registers.
    logic [TW-1:0]                 alarm_lim_reg;
    logic [otla_pkg::CFG_W-1:0]    sens_lo_reg;
    logic [otla_pkg::CFG_W-1:0]    sens_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_lim_reg <= otla_pkg::ALARM_LIMIT_RST;
            sens_lo_reg   <= otla_pkg::SENSOR_LO_RST;
            sens_hi_reg   <= otla_pkg::SENSOR_HI_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                otla_pkg::CFG_ALARM_LIMIT: alarm_lim_reg <= cfg_data[TW-1:0];
                otla_pkg::CFG_SENSOR_LO:   sens_lo_reg   <= cfg_data;
                otla_pkg::CFG_SENSOR_HI:   sens_hi_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input sample.
    logic [otla_pkg::RES_W-1:0] res_reg;

    always_ff @(posedge aclk) begin
        if (cmd.lat_in) begin
            res_reg <= res_in;
        end
    end

    // Segment selection and interpolation. The top bits of the product of the
    // offset and the scaled slope give the truncated rise within the segment.
    otla_pkg::otla_seg_t          seg;
    logic [otla_pkg::RES_W-1:0]   off;
    logic [otla_pkg::PROD_W-1:0]  lin_prod;
    logic [TW-1:0]                lin_t;
    logic [TW-1:0]                lin_t_reg;

    assign seg      = otla_pkg::seg_lookup(res_reg);
    assign off      = res_reg - seg.lo;
    assign lin_prod = otla_pkg::PROD_W'(off[otla_pkg::SPAN_W-1:0])
                    * otla_pkg::PROD_W'(seg.rcp);
    assign lin_t    = seg.t0 + TW'(lin_prod[otla_pkg::PROD_W-1:otla_pkg::RCP_SHIFT]);

    always_ff @(posedge aclk) begin
        if (cmd.ram_rd) begin
            lin_t_reg <= lin_t;
        end
    end

    // Window state. Slots at or beyond the fill count were never written and
    // read as zero, so the store needs no clearing.
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [TW-1:0]    filt_reg, filt_next;
    logic [TW-1:0]    ram_q;
    logic [TW-1:0]    old_t;
    logic [TW-1:0]    new_t;
    logic [SUM_W-1:0] quot;
    logic             div_busy;

    assign new_t = lin_t_reg;
    assign old_t = (CNT_W'(wptr_reg) < count_reg) ? ram_q : '0;

    always_comb begin
        wptr_next  = wptr_reg;
        count_next = count_reg;
        sum_next   = sum_reg - SUM_W'(old_t) + SUM_W'(new_t);
        filt_next  = filt_reg;
        if (count_reg != CNT_W'(WINDOW)) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (wptr_reg == PTR_W'(WINDOW - 1)) begin
            wptr_next = '0;
        end else begin
            wptr_next = wptr_reg + PTR_W'(1);
        end
        if (cmd.filt_load) begin
            filt_next = quot[TW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            filt_reg  <= '0;
        end else begin
            if (cmd.win_upd) begin
                wptr_reg  <= wptr_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
            filt_reg <= filt_next;
        end
    end

    otla_ram #(
        .WIDTH (TW),
        .DEPTH (WINDOW)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (cmd.win_upd),
        .wr_addr (wptr_reg),
        .wr_data (new_t),
        .rd_en   (cmd.ram_rd),
        .rd_addr (wptr_reg),
        .rd_data (ram_q)
    );

    // Divider for the window average: the updated sum over the updated count.
    otla_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (sum_next),
        .den     (count_next),
        .busy    (div_busy),
        .quot    (quot)
    );

    assign status.div_busy = div_busy;

    // Output word register.
    logic [TW-1:0] out_temp_reg;
    logic          out_alarm_reg;
    logic          out_err_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_temp_reg  <= filt_reg;
            out_alarm_reg <= (filt_reg > alarm_lim_reg);
            out_err_reg   <= (res_reg < sens_lo_reg) || (res_reg > sens_hi_reg);
        end
    end

    assign filtered_temp = out_temp_reg;
    assign high_alarm    = out_alarm_reg;
    assign sensor_error  = out_err_reg;

endmodule

### hdl/otla_ctrl.sv
module otla_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tick,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output otla_pkg::otla_cmd_t    cmd,
    input  otla_pkg::otla_status_t status
);

    otla_pkg::otla_state_t state_reg, state_next;
    logic                  mvalid_reg, mvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            otla_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.lat_in = 1'b1;
                    state_next = s_tick ? otla_pkg::ST_LIN : otla_pkg::ST_OUT;
                end
            end
            otla_pkg::ST_LIN: begin
                cmd.ram_rd = 1'b1;
                state_next = otla_pkg::ST_UPD;
            end
            otla_pkg::ST_UPD: begin
                cmd.win_upd   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = otla_pkg::ST_SWAIT;
            end
            otla_pkg::ST_SWAIT: begin
                if (!status.div_busy) begin
                    cmd.filt_load = 1'b1;
                    state_next    = otla_pkg::ST_OUT;
                end
            end
            otla_pkg::ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = otla_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = otla_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= otla_pkg::ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule

### hdl/oil_temp_linearize_average_core.sv
// Channel  | Direction | Ports                              | Word contents
// ---------+-----------+------------------------------------+---------------------------------
// s_       | in        | s_tvalid s_tready s_tdata s_tuser  | res (tdata), sample_tick (tuser)
// m_       | out       | m_tvalid m_tready m_tdata          | filtered_temp, high_alarm,
//          |           |                                    | sensor_error
// cfg_     | in        | cfg_valid cfg_ready cfg_index      | register index and value
//          |           | cfg_data                           |
//
// A word without a tick goes straight to the output stage, which loads the result
// as soon as the output register is empty or its word is being taken on m_.
// A word with a tick goes through accept, linearize and read the oldest entry,
// update the window, restoring division for the average (the window sum SUM_W is
// 13 bits at the default window of 70), and the output load, which waits in the
// same way for the output register.
// Reset is synchronous and active low; the window store needs no clearing pass.
// A word is taken only while the controller is idle; a finished result waits in
// the output register, and the next word is accepted while it waits.
module oil_temp_linearize_average_core #(
    parameter int WINDOW = otla_pkg::WINDOW_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    // Input stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [15:0] res
    input  logic                        s_tuser,   // [0] sample_tick

    // Result stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [6:0] filtered_temp, [7] high_alarm,
                                                   // [8] sensor_error, [15:9] zero

    // Configuration writes.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [otla_pkg::IDX_W-1:0]  cfg_index,
    input  logic [otla_pkg::CFG_W-1:0]  cfg_data
);

    otla_pkg::otla_cmd_t          cmd;
    otla_pkg::otla_status_t       status;
    logic [otla_pkg::TEMP_W-1:0]  filtered_temp;
    logic                         high_alarm;
    logic                         sensor_error;

    // Configuration writes are always taken and go straight into the configuration registers.
    assign cfg_ready = 1'b1;

    // The controller sequences the datapath and owns both handshakes.
    otla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tick   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // The datapath holds the configuration, the window, the divider and the
    // output word register.
    otla_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .res_in        (s_tdata),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .filtered_temp (filtered_temp),
        .high_alarm    (high_alarm),
        .sensor_error  (sensor_error)
    );

    // Pack the result fields from the lowest bit up and pad to whole bytes.
    assign m_tdata = {7'b0, sensor_error, high_alarm, filtered_temp};

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // Window depth used for the instance and for the prediction.
    localparam int WIN_DEPTH = 70;
    // Quiet cycles allowed before the run is declared hung. The slowest legal
    // gap between two handshakes is a tick word plus the longest sender gap and
    // receiver stall, well below this.
    localparam int IDLE_LIMIT = 3000;
    // Cycles to keep watching the result port after the last result.
    localparam int TAIL_CYCLES = 40;
    // Register index that maps to nothing; writes to it must be dropped.
    localparam logic [otla_pkg::IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // Breakpoints of the sensor curve, lowest first; the last one is the
    // top of the curve.
    localparam int CURVE_BRK [15] = '{
        1077, 1116, 1155, 1174, 1194, 1213, 1232, 1251,
        1270, 1289, 1309, 1328, 1347, 1366, 1385
    };

    typedef struct {
        logic [6:0] degc;
        logic       alarm;
        logic       fault;
    } reading_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;

    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata = '0;   // [15:0] res
    logic             s_tuser = 1'b0; // [0] sample_tick

    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;        // [6:0] filtered_temp, [7] high_alarm,
                                      // [8] sensor_error, [15:9] zero

    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [otla_pkg::IDX_W-1:0]   cfg_index = '0;
    logic [otla_pkg::CFG_W-1:0]   cfg_data = '0;

    oil_temp_linearize_average_core #(
        .WINDOW(WIN_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the block's registers and averaging state. All of it is
    // updated at the clock edge where the matching handshake happens.
    logic [6:0]  lim_alarm = 7'd90;
    logic [15:0] lim_lo    = 16'd300;
    logic [15:0] lim_hi    = 16'd60000;
    logic [6:0]  win_store [WIN_DEPTH];
    int          wr_ptr    = 0;
    int          fill_cnt  = 0;
    int          win_sum   = 0;
    logic [6:0]  avg_degc  = '0;

    // Readings predicted for accepted words, oldest first.
    reading_t pending_readings [$];
    int       err_count = 0;

    // Idling controls, changed by the tests between phases.
    bit tx_gaps    = 1'b1;
    bit rx_stalls  = 1'b1;
    int burst_left = 0;
    int rx_run     = 0;
    int quiet_cycles = 0;

    initial begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win_store[i] = '0;
        end
    end

    // Resistance to whole degrees: clamp outside the curve, otherwise find
    // the segment and interpolate with truncation. The first two segments
    // span 10 degrees, all later ones 5.
    function automatic logic [6:0] res_to_degc(input logic [15:0] r);
        int k;
        int base;
        int rise;
        if (r >= CURVE_BRK[14]) begin
            return 7'd100;
        end
        if (r < CURVE_BRK[0]) begin
            return 7'd20;
        end
        k = 0;
        while (k < 13 && r >= CURVE_BRK[k + 1]) begin
            k++;
        end
        rise = (k < 2) ? 10 : 5;
        base = (k < 2) ? 20 + 10 * k : 40 + 5 * (k - 2);
        return 7'(base + ((int'(r) - CURVE_BRK[k]) * rise) / (CURVE_BRK[k + 1] - CURVE_BRK[k]));
    endfunction

    // Advances the averaging state for one accepted word and queues the
    // reading the block must return for it.
    task automatic predict_reading(input logic [15:0] r, input logic tick);
        reading_t   want;
        logic [6:0] degc;
        if (tick) begin
            degc = res_to_degc(r);
            if (fill_cnt < WIN_DEPTH) begin
                fill_cnt++;
            end
            win_sum = win_sum - win_store[wr_ptr] + degc;
            win_store[wr_ptr] = degc;
            wr_ptr = (wr_ptr + 1) % WIN_DEPTH;
            avg_degc = 7'(win_sum / fill_cnt);
        end
        want.degc  = avg_degc;
        want.alarm = avg_degc > lim_alarm;
        want.fault = (r < lim_lo) || (r > lim_hi);
        pending_readings.push_back(want);
    endtask

    // Sends one word. The valid stays high after the handshake so that the
    // next word can follow back to back; any caller that spends time before
    // the next word either takes a gap here or drains, both of which lower it.
    task automatic push_word(input logic [15:0] r, input logic tick);
        int gap;
        if (tx_gaps && burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        s_tuser  <= tick;
        do @(posedge aclk); while (!s_tready);
        predict_reading(r, tick);
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // Holds the sender off until every predicted reading has been returned.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_readings.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Writes all three limits and then a stray write to the unmapped index.
    // Only called with the block idle, so the new limits apply to the next
    // word. Only the low seven bits of the alarm word are meaningful.
    task automatic write_regs(input logic [15:0] alarm_word, input logic [15:0] lo,
                              input logic [15:0] hi);
        logic [otla_pkg::IDX_W-1:0] idx [4];
        logic [otla_pkg::CFG_W-1:0] val [4];
        wait_drained();
        idx = '{otla_pkg::CFG_ALARM_LIMIT, otla_pkg::CFG_SENSOR_LO,
                otla_pkg::CFG_SENSOR_HI, CFG_UNMAPPED};
        val = '{alarm_word, lo, hi, 16'($urandom)};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                otla_pkg::CFG_ALARM_LIMIT: lim_alarm = val[i][6:0];
                otla_pkg::CFG_SENSOR_LO:   lim_lo = val[i];
                otla_pkg::CFG_SENSOR_HI:   lim_hi = val[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Receiver: runs of random length in which it is either ready or stalled.
    always @(posedge aclk) begin
        if (!rx_stalls) begin
            m_tready <= 1'b1;
        end else if (rx_run == 0) begin
            m_tready <= ($urandom_range(0, 4) < 3);
            rx_run = $urandom_range(1, 24);
        end else begin
            rx_run--;
        end
    end

    // Every returned word is compared with the oldest prediction. Values are
    // listed as temperature, alarm and error flag.
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                err_count++;
                $display("%0t: result word %h with nothing expected", $time, m_tdata);
            end else begin
                want = pending_readings.pop_front();
                if (m_tdata[6:0] !== want.degc || m_tdata[7] !== want.alarm ||
                    m_tdata[8] !== want.fault || m_tdata[15:9] !== 7'd0) begin
                    err_count++;
                    $display("%0t: expected %0d %0b %0b pad 0, got %0d %0b %0b pad %0h",
                             $time, want.degc, want.alarm, want.fault,
                             m_tdata[6:0], m_tdata[7], m_tdata[8], m_tdata[15:9]);
                end
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // Words without a tick before the first tick: the average must read zero
    // while the error flag follows the reset limits on both sides.
    task automatic test_reset_state();
        push_word(16'd1000, 1'b0);
        push_word(16'd0, 1'b0);
        push_word(16'd299, 1'b0);
        push_word(16'd300, 1'b0);
        push_word(16'd60000, 1'b0);
        push_word(16'd60001, 1'b0);
        push_word(16'hFFFF, 1'b0);
    endtask

    // Both clamps, segment edges, and the 85 to 90 degree segment whose span
    // is 19, all while the window is still filling.
    task automatic test_curve_corners();
        push_word(16'd1076, 1'b1);
        push_word(16'd1077, 1'b1);
        push_word(16'd1115, 1'b1);
        push_word(16'd1116, 1'b1);
        push_word(16'd1173, 1'b1);
        push_word(16'd1327, 1'b1);
        push_word(16'd1328, 1'b1);
        push_word(16'd1346, 1'b1);
        push_word(16'd1347, 1'b1);
        push_word(16'd1384, 1'b1);
        push_word(16'd1385, 1'b1);
        push_word(16'hFFFF, 1'b1);
        push_word(16'd0, 1'b1);
        push_word(16'd1200, 1'b0);
    endtask

    // Extreme limit settings: alarm at zero, alarm above the curve with junk
    // in the upper data bits, fully open and crossed sensor limits.
    task automatic test_register_extremes();
        write_regs(16'hFF80, 16'd0, 16'hFFFF);
        push_word(16'd0, 1'b0);
        push_word(16'hFFFF, 1'b1);
        push_word(16'd1200, 1'b1);
        write_regs(16'hFFFF, 16'hFFFF, 16'd0);
        push_word(16'd0, 1'b0);
        push_word(16'h8000, 1'b0);
        push_word(16'hFFFF, 1'b1);
        write_regs(16'd100, 16'd1000, 16'd1000);
        push_word(16'd999, 1'b0);
        push_word(16'd1000, 1'b1);
        push_word(16'd1001, 1'b0);
        write_regs(16'd90, 16'd300, 16'd60000);
    endtask

    // Fill the window past saturation at the top of the curve, then push it
    // down with cold readings so the oldest entries get replaced.
    task automatic test_window_wrap();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        write_regs(16'd95, 16'd300, 16'd60000);
        for (int i = 0; i < 170; i++) begin
            if (i % 6 == 5) begin
                push_word(16'($urandom), 1'b0);
            end else if (i < 85) begin
                push_word(16'd1385 + 16'($urandom_range(0, 200)), 1'b1);
            end else begin
                push_word(16'($urandom_range(900, 1100)), 1'b1);
            end
        end
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // Half of the picks are readings around the curve; the rest are breakpoints,
    // values around the current sensor limits and the whole 16-bit range.
    function automatic logic [15:0] pick_res();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(1060, 1400);
            5:             v = CURVE_BRK[$urandom_range(0, 14)] + $urandom_range(0, 2) - 1;
            6:             v = int'(lim_lo) + $urandom_range(0, 2) - 1;
            7:             v = int'(lim_hi) + $urandom_range(0, 2) - 1;
            default:       v = $urandom_range(0, 65535);
        endcase
        return 16'(v);
    endfunction

    task automatic test_random_traffic();
        logic [15:0] alarm_word;
        logic [15:0] lo;
        logic [15:0] hi;
        for (int phase = 0; phase < 8; phase++) begin
            alarm_word = {9'($urandom), 7'($urandom_range(30, 100))};
            if (phase % 4 == 3) begin
                alarm_word[6:0] = 7'($urandom_range(0, 127));
            end
            lo = 16'($urandom_range(0, 1500));
            hi = 16'($urandom_range(1000, 65535));
            if (phase == 5) begin
                lo = 16'($urandom);
                hi = 16'($urandom);
            end
            write_regs(alarm_word, lo, hi);
            // Phases 0 and 4 run without any idling on either side.
            tx_gaps = (phase % 4 != 0);
            rx_stalls = (phase % 4 != 0) && (phase != 6);
            for (int i = 0; i < 220; i++) begin
                if ($urandom_range(0, 99) == 0) begin
                    wait_drained();
                end
                push_word(pick_res(), 1'($urandom_range(0, 2) != 0));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_curve_corners();
        test_register_extremes();
        test_window_wrap();
        test_random_traffic();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0 && pending_readings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
